/* hdl/ppa_pkg.sv */
// ----------------------------------------------------------------------------
// ppa_pkg: shared types and stage arithmetic
// Register indexes, the configuration bundle, the in-flight item record and
// the per-stage function of the point attractor Euler step pipeline.
// ----------------------------------------------------------------------------
package ppa_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_ATTRACT_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTRACT_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTRACT_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEL     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STEP = 3'd4;

   localparam logic [31:0] ACCEL_RESET = 32'd65536;
   localparam logic [15:0] DT_RESET    = 16'd1092;

   // stage map
   localparam int ST_INPUT    = 0;
   localparam int ST_DIFF     = 1;
   localparam int ST_NORM     = 2;
   localparam int ST_SQUARE   = 3;
   localparam int ST_SUM      = 4;
   localparam int ST_SQRT0    = 5;
   localparam int SQRT_STEPS  = 32;
   localparam int SQRT_STAGES = SQRT_STEPS / 2;
   localparam int ST_DIV0     = ST_SQRT0 + SQRT_STAGES;
   localparam int DIV_STEPS   = 17;
   localparam int DIV_STAGES  = (DIV_STEPS + 1) / 2;
   localparam int ST_MUL_LO   = ST_DIV0 + DIV_STAGES;
   localparam int ST_MUL_HI   = ST_MUL_LO + 1;
   localparam int ST_VEL      = ST_MUL_HI + 1;
   localparam int ST_DT_MUL   = ST_VEL + 1;
   localparam int ST_POS      = ST_DT_MUL + 1;
   localparam int NUM_STAGES  = ST_POS + 1;

   typedef struct packed {
      logic [2:0][31:0] attract;
      logic [31:0]      accel;
      logic [15:0]      dt;
   } cfg_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0]       dneg;
      logic [2:0][32:0] dm;
      logic             ianeg;
      logic [46:0]      iam;
      logic [2:0][61:0] sq;
      logic [63:0]      sx;
      logic [63:0]      sres;
      logic [2:0][47:0] rem;
      logic [2:0][16:0] quo;
      logic [2:0][63:0] prod;
      logic [2:0][31:0] nv;
      logic [2:0][47:0] dpm;
      logic [2:0][31:0] np;
   } item_type;

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
         r = v[31:0];
      end else if (v[34]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic item_type stage_fn(input int s, input cfg_type c, input item_type a);
      item_type                r;
      logic signed [32:0]      d;
      logic signed [47:0]      ia;
      logic [32:0]             m;
      logic [63:0]             t;
      logic [63:0]             bitv;
      logic [47:0]             dd;
      logic [31:0]             dvr;
      logic [31:0]             mag;
      logic [32:0]             rr;
      logic signed [34:0]      addend;
      logic                    neg;
      int                      bl;
      int                      step;
      int                      i;
      r = a;
      if (s == ST_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            d = $signed({c.attract[k][31], c.attract[k]}) - $signed({a.pos[k][31], a.pos[k]});
            r.dneg[k] = d[32];
            r.dm[k]   = d[32] ? 33'(-d) : 33'(d);
         end
         ia      = $signed({{16{c.accel[31]}}, c.accel}) * $signed({32'd0, c.dt});
         r.ianeg = ia[47];
         r.iam   = ia[47] ? 47'(-ia) : 47'(ia);
      end else if (s == ST_NORM) begin
         m = a.dm[0];
         if (a.dm[1] > m) m = a.dm[1];
         if (a.dm[2] > m) m = a.dm[2];
         bl = 0;
         for (int b = 0; b < 33; b++) begin
            if (m[b]) bl = b + 1;
         end
         // bring the largest magnitude to exactly 31 bits
         for (int k = 0; k < 3; k++) begin
            if (bl > 31) r.dm[k] = a.dm[k] >> (bl - 31);
            else         r.dm[k] = a.dm[k] << (31 - bl);
         end
      end else if (s == ST_SQUARE) begin
         for (int k = 0; k < 3; k++) begin
            r.sq[k] = a.dm[k][30:0] * a.dm[k][30:0];
         end
      end else if (s == ST_SUM) begin
         r.sx   = 64'(a.sq[0]) + 64'(a.sq[1]) + 64'(a.sq[2]);
         r.sres = '0;
         for (int k = 0; k < 3; k++) begin
            r.rem[k] = {1'b0, a.dm[k][30:0], 16'h0000};
            r.quo[k] = '0;
         end
      end else if (s >= ST_SQRT0 && s < ST_DIV0) begin
         // two digit steps of the bitwise integer square root
         for (int j = 0; j < 2; j++) begin
            step = (s - ST_SQRT0) * 2 + j;
            bitv = 64'd1 << (62 - 2 * step);
            t    = r.sres + bitv;
            if (r.sx >= t) begin
               r.sx   = r.sx - t;
               r.sres = (r.sres >> 1) + bitv;
            end else begin
               r.sres = r.sres >> 1;
            end
         end
      end else if (s >= ST_DIV0 && s < ST_MUL_LO) begin
         // up to two quotient bits per axis of the restoring divide by the norm
         for (int j = 0; j < 2; j++) begin
            step = (s - ST_DIV0) * 2 + j;
            if (step < DIV_STEPS) begin
               i  = DIV_STEPS - 1 - step;
               dd = {16'h0000, a.sres[31:0]} << i;
               for (int k = 0; k < 3; k++) begin
                  if (r.rem[k] >= dd) begin
                     r.rem[k] = r.rem[k] - dd;
                     r.quo[k] = r.quo[k] | (17'd1 << i);
                  end
               end
            end
         end
      end else if (s == ST_MUL_LO) begin
         for (int k = 0; k < 3; k++) begin
            // on the attractor: no direction, no acceleration
            if (a.sres == 64'd0) r.quo[k] = '0;
            r.prod[k] = {47'd0, r.quo[k]} * {32'd0, a.iam[31:0]};
         end
      end else if (s == ST_MUL_HI) begin
         for (int k = 0; k < 3; k++) begin
            r.prod[k] = a.prod[k] + (({47'd0, a.quo[k]} * {49'd0, a.iam[46:32]}) << 32);
         end
      end else if (s == ST_VEL) begin
         for (int k = 0; k < 3; k++) begin
            dvr    = 32'((a.prod[k] + 64'h8000_0000) >> 32);
            neg    = a.dneg[k] ^ a.ianeg;
            addend = neg ? -$signed({3'b000, dvr}) : $signed({3'b000, dvr});
            r.nv[k] = sat32(35'($signed(a.vel[k])) + addend);
         end
      end else if (s == ST_DT_MUL) begin
         for (int k = 0; k < 3; k++) begin
            mag      = a.nv[k][31] ? 32'(-a.nv[k]) : a.nv[k];
            r.dpm[k] = mag * c.dt;
         end
      end else if (s == ST_POS) begin
         for (int k = 0; k < 3; k++) begin
            rr     = 33'((a.dpm[k] + 48'h8000) >> 16);
            addend = a.nv[k][31] ? -$signed({2'b00, rr}) : $signed({2'b00, rr});
            r.np[k] = sat32(35'($signed(a.pos[k])) + addend);
         end
      end
      return r;
   endfunction

endpackage

/* hdl/ppa_req_if.sv */
// ----------------------------------------------------------------------------
// ppa_req_if: particle input channel
// Valid/ready channel carrying one particle's position and velocity.
// ----------------------------------------------------------------------------
interface ppa_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

/* hdl/ppa_rsp_if.sv */
// ----------------------------------------------------------------------------
// ppa_rsp_if: particle result channel
// Valid/ready channel carrying the updated position and velocity.
// ----------------------------------------------------------------------------
interface ppa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;

   modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, input ready);
   modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

/* hdl/particle_point_attractor_step_unit.sv */
// ----------------------------------------------------------------------------
// particle_point_attractor_step_unit: point attractor Euler step
// Pulls each particle toward a configured point with constant acceleration
// and integrates velocity and position over one time step, saturating.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_port  in         pos_x/y/z, vel_x/y/z          (valid/ready)
//  rsp_port  out        new_pos_x/y/z, new_vel_x/y/z  (valid/ready)
//  csr_*     in         write enable, index, data     (no read-back)
//
// One item per cycle is accepted unless every stage holds an item and the output
// stalls; the pipeline holds the 16-stage square root and the 9-stage divide for the unit vector.
// Reset clears every stage valid and loads the register reset values.
// A stalled output holds its item; each stage advances whenever it is empty
// or the stage after it advances, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module particle_point_attractor_step_unit (
   input  logic                           clock,
   input  logic                           reset,
   ppa_req_if.sink                        req_port,
   ppa_rsp_if.source                      rsp_port,
   input  logic                           csr_we,
   input  logic [ppa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ppa_pkg::*;

   cfg_type                 cfg_ff;
   item_type                in_item;
   item_type                items [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valids;
   logic [NUM_STAGES-1:0]   adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attract <= '0;
         cfg_ff.accel   <= ACCEL_RESET;
         cfg_ff.dt      <= DT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ATTRACT_X: cfg_ff.attract[0] <= csr_wdata;
            REG_ATTRACT_Y: cfg_ff.attract[1] <= csr_wdata;
            REG_ATTRACT_Z: cfg_ff.attract[2] <= csr_wdata;
            REG_ACCEL:     cfg_ff.accel      <= csr_wdata;
            REG_TIME_STEP: cfg_ff.dt         <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_item        = '0;
      in_item.pos[0] = req_port.pos_x;
      in_item.pos[1] = req_port.pos_y;
      in_item.pos[2] = req_port.pos_z;
      in_item.vel[0] = req_port.vel_x;
      in_item.vel[1] = req_port.vel_y;
      in_item.vel[2] = req_port.vel_z;
   end

   assign adv[NUM_STAGES-1] = !valids[NUM_STAGES-1] || rsp_port.ready;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      if (s < NUM_STAGES - 1) begin : g_adv
         assign adv[s] = !valids[s] || adv[s+1];
      end
      if (s == 0) begin : g_first
         ppa_stage #(.STAGE(s)) u_stage (
            .clock    (clock),
            .reset    (reset),
            .cfg      (cfg_ff),
            .up_item  (in_item),
            .up_valid (req_port.valid),
            .load     (adv[s]),
            .item     (items[s]),
            .valid    (valids[s])
         );
      end else begin : g_next
         ppa_stage #(.STAGE(s)) u_stage (
            .clock    (clock),
            .reset    (reset),
            .cfg      (cfg_ff),
            .up_item  (items[s-1]),
            .up_valid (valids[s-1]),
            .load     (adv[s]),
            .item     (items[s]),
            .valid    (valids[s])
         );
      end
   end

   assign req_port.ready     = adv[0];
   assign rsp_port.valid     = valids[NUM_STAGES-1];
   assign rsp_port.new_pos_x = items[NUM_STAGES-1].np[0];
   assign rsp_port.new_pos_y = items[NUM_STAGES-1].np[1];
   assign rsp_port.new_pos_z = items[NUM_STAGES-1].np[2];
   assign rsp_port.new_vel_x = items[NUM_STAGES-1].nv[0];
   assign rsp_port.new_vel_y = items[NUM_STAGES-1].nv[1];
   assign rsp_port.new_vel_z = items[NUM_STAGES-1].nv[2];

   // input backs up only when every stage holds an item and the output stalls
   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      req_port.ready == (!(&valids) || rsp_port.ready))
      else $error("ready does not follow pipeline occupancy");

   a_enter : assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> valids[0])
      else $error("accepted item missing from first stage");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> valids == '0)
      else $error("pipeline not empty after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      valids[NUM_STAGES-1] && !rsp_port.ready |=>
         valids[NUM_STAGES-1] && $stable(items[NUM_STAGES-1]))
      else $error("stalled output item changed");
endmodule

/* hdl/ppa_stage.sv */
// ----------------------------------------------------------------------------
// ppa_stage: one pipeline register stage
// Applies the arithmetic of its stage number and holds the item and its valid.
// ----------------------------------------------------------------------------
module ppa_stage #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  ppa_pkg::cfg_type  cfg,
   input  ppa_pkg::item_type up_item,
   input  logic              up_valid,
   input  logic              load,
   output ppa_pkg::item_type item,
   output logic              valid
);
   import ppa_pkg::*;

   item_type item_ff;
   item_type item_in;
   logic     valid_ff;

   assign item_in = stage_fn(STAGE, cfg, up_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item  = item_ff;
   assign valid = valid_ff;
endmodule
